// File: hw/rtl/assert_macros.svh
// assertion macros used by the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// next-cycle implication, switched off while reset is held
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// next-cycle implication that also runs through reset
`define ASSERT_NEXT_ANY(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hw/rtl/pmbr_pkg.sv
// types, constants and codes of the page map block reserver
package pmbr_pkg;

    localparam int SEC_PER_PAGE = 8;
    localparam int PAGE_PER_BLK = 64;
    localparam int NUM_BLOCKS   = 1024;
    localparam int MAP_PAGES    = 4096;
    localparam int SEC_PER_BLK  = SEC_PER_PAGE * PAGE_PER_BLK;

    localparam int START_W = 15;
    localparam int COUNT_W = 13;
    localparam int BLK_W   = 10;
    localparam int ENTRY_W = BLK_W + 1;
    localparam int PAGE_W  = $clog2(MAP_PAGES);
    localparam int FILL_W  = $clog2(PAGE_PER_BLK + 1);
    localparam int NEXT_W  = $clog2(NUM_BLOCKS + 1);
    localparam int END_W   = START_W + 1;
    localparam int LPAGE_W = END_W - $clog2(SEC_PER_PAGE);

    typedef logic [START_W-1:0] t_start;
    typedef logic [COUNT_W-1:0] t_count;
    typedef logic [BLK_W-1:0]   t_blk;
    typedef logic [ENTRY_W-1:0] t_entry;
    typedef logic [PAGE_W-1:0]  t_page;
    typedef logic [FILL_W-1:0]  t_fill;
    typedef logic [FILL_W:0]    t_fill_sum;
    typedef logic [NEXT_W-1:0]  t_next;
    typedef logic [END_W-1:0]   t_end;
    typedef logic [LPAGE_W-1:0] t_lpage;

    localparam logic [1:0] REQ_RESERVE = 2'd0;
    localparam logic [1:0] REQ_COMMIT  = 2'd1;
    localparam logic [1:0] REQ_READ    = 2'd2;

    typedef struct packed {
        logic [1:0] req_type;
        t_start     first_sector;
        t_count     sector_count;
        t_blk       commit_block;
    } t_req;

    typedef struct packed {
        t_blk   block_addr;
        logic   block_valid;
        t_blk   prior_block;
        logic   prior_valid;
        t_count chunk_sectors;
    } t_rsp;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_EVAL,
        ST_WRITE,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic capture;
        logic clear_step;
        logic lookup;
        logic eval;
        logic write_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic clear_last;
        logic write_last;
        logic commit_run;
    } t_sts;

endpackage

// File: hw/rtl/pmbr_ctrl.sv
// sequencer: map clear sweep, lookup, evaluate, commit writes, result hand-off
module pmbr_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    output logic            o_valid,
    input  logic            i_ready,
    input  pmbr_pkg::t_sts  i_sts,
    output pmbr_pkg::t_cmd  o_cmd
);

    pmbr_pkg::t_state r_state, n_state;
    logic             r_out_valid, n_out_valid;
    logic             out_free;

    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            pmbr_pkg::ST_CLEAR: begin
                if (i_sts.clear_last) n_state = pmbr_pkg::ST_IDLE;
            end
            pmbr_pkg::ST_IDLE: begin
                if (i_valid) n_state = pmbr_pkg::ST_LOOKUP;
            end
            pmbr_pkg::ST_LOOKUP: begin
                n_state = pmbr_pkg::ST_EVAL;
            end
            pmbr_pkg::ST_EVAL: begin
                n_state = i_sts.commit_run ? pmbr_pkg::ST_WRITE : pmbr_pkg::ST_FINISH;
            end
            pmbr_pkg::ST_WRITE: begin
                if (i_sts.write_last) n_state = pmbr_pkg::ST_FINISH;
            end
            pmbr_pkg::ST_FINISH: begin
                if (out_free) n_state = pmbr_pkg::ST_IDLE;
            end
            default: begin
                n_state = pmbr_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_cmd            = '0;
        o_ready          = 1'b0;
        o_cmd.capture    = (r_state == pmbr_pkg::ST_IDLE) && i_valid;
        o_cmd.clear_step = (r_state == pmbr_pkg::ST_CLEAR);
        o_cmd.lookup     = (r_state == pmbr_pkg::ST_LOOKUP);
        o_cmd.eval       = (r_state == pmbr_pkg::ST_EVAL);
        o_cmd.write_step = (r_state == pmbr_pkg::ST_WRITE);
        o_cmd.load_out   = (r_state == pmbr_pkg::ST_FINISH) && out_free;
        o_ready          = (r_state == pmbr_pkg::ST_IDLE);
    end

    // result register stays full until the far side takes the transfer
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    assign o_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pmbr_pkg::ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// File: hw/rtl/pmbr_dp.sv
// datapath: page table memory, open block tracking, grant and lookup arithmetic
module pmbr_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  pmbr_pkg::t_req  i_req,
    input  pmbr_pkg::t_cmd  i_cmd,
    output pmbr_pkg::t_sts  o_sts,
    output pmbr_pkg::t_rsp  o_rsp
);

    pmbr_pkg::t_entry r_mem [0:pmbr_pkg::MAP_PAGES-1];

    pmbr_pkg::t_req   r_req;
    pmbr_pkg::t_entry r_rdata;
    pmbr_pkg::t_page  r_page;
    pmbr_pkg::t_page  r_last;
    pmbr_pkg::t_blk   r_open_block;
    logic             r_open_valid;
    pmbr_pkg::t_fill  r_fill;
    pmbr_pkg::t_next  r_next;
    pmbr_pkg::t_rsp   r_res, n_res;
    pmbr_pkg::t_rsp   r_rsp;

    pmbr_pkg::t_page     first_page;
    pmbr_pkg::t_end      tail_sector;
    pmbr_pkg::t_lpage    last_page;
    pmbr_pkg::t_page     last_clip;
    pmbr_pkg::t_lpage    needed;
    pmbr_pkg::t_fill     eff_fill;
    pmbr_pkg::t_blk      eff_block;
    pmbr_pkg::t_fill     room;
    pmbr_pkg::t_fill     to_edge;
    pmbr_pkg::t_fill     avail;
    pmbr_pkg::t_fill     use_pages;
    pmbr_pkg::t_fill_sum new_fill;
    pmbr_pkg::t_count    grant_chunk;
    pmbr_pkg::t_count    left;
    pmbr_pkg::t_count    read_chunk;
    logic                fits;
    logic                count_nz;
    logic                can_open;
    logic                grant;
    logic                hit;
    logic                wr_en;
    pmbr_pkg::t_entry    wr_data;

    assign first_page  = pmbr_pkg::t_page'(r_req.first_sector / pmbr_pkg::SEC_PER_PAGE);
    assign tail_sector = pmbr_pkg::t_end'(r_req.first_sector)
                       + pmbr_pkg::t_end'(r_req.sector_count) - pmbr_pkg::t_end'(1);
    assign last_page   = pmbr_pkg::t_lpage'(tail_sector / pmbr_pkg::SEC_PER_PAGE);
    assign last_clip   = (last_page >= pmbr_pkg::t_lpage'(pmbr_pkg::MAP_PAGES))
                       ? pmbr_pkg::t_page'(pmbr_pkg::MAP_PAGES - 1)
                       : pmbr_pkg::t_page'(last_page);
    assign needed      = last_page - pmbr_pkg::t_lpage'(first_page) + pmbr_pkg::t_lpage'(1);

    // a block opened by this request starts empty
    assign eff_fill  = r_open_valid ? r_fill : '0;
    assign eff_block = r_open_valid ? r_open_block : pmbr_pkg::t_blk'(r_next);
    assign room      = pmbr_pkg::t_fill'(pmbr_pkg::PAGE_PER_BLK) - eff_fill;
    assign to_edge   = pmbr_pkg::t_fill'(pmbr_pkg::PAGE_PER_BLK)
                     - pmbr_pkg::t_fill'(first_page % pmbr_pkg::PAGE_PER_BLK);
    assign avail     = (room < to_edge) ? room : to_edge;
    assign fits      = (pmbr_pkg::t_lpage'(avail) >= needed);
    assign use_pages = fits ? pmbr_pkg::t_fill'(needed) : avail;
    assign new_fill  = {1'b0, eff_fill} + {1'b0, use_pages};
    assign grant_chunk = fits ? r_req.sector_count
                       : pmbr_pkg::t_count'(avail) * pmbr_pkg::t_count'(pmbr_pkg::SEC_PER_PAGE);

    assign count_nz = (r_req.sector_count != '0);
    assign can_open = (r_next < pmbr_pkg::t_next'(pmbr_pkg::NUM_BLOCKS));
    assign grant    = count_nz && (r_open_valid || can_open);

    // on a hit the read chunk is clipped to the logical block edge
    assign hit        = r_rdata[pmbr_pkg::BLK_W];
    assign left       = pmbr_pkg::t_count'(pmbr_pkg::SEC_PER_BLK)
                      - pmbr_pkg::t_count'(r_req.first_sector % pmbr_pkg::SEC_PER_BLK);
    assign read_chunk = (hit && (left < r_req.sector_count)) ? left : r_req.sector_count;

    always_comb begin
        n_res = '0;
        unique case (r_req.req_type)
            pmbr_pkg::REQ_RESERVE: begin
                n_res.prior_valid = hit;
                n_res.prior_block = hit ? r_rdata[pmbr_pkg::BLK_W-1:0] : '0;
                if (grant) begin
                    n_res.block_addr    = eff_block;
                    n_res.block_valid   = 1'b1;
                    n_res.chunk_sectors = grant_chunk;
                end
            end
            pmbr_pkg::REQ_COMMIT: begin
                n_res.block_addr    = r_req.commit_block;
                n_res.block_valid   = 1'b1;
                n_res.chunk_sectors = r_req.sector_count;
            end
            pmbr_pkg::REQ_READ: begin
                n_res.block_addr    = hit ? r_rdata[pmbr_pkg::BLK_W-1:0] : '0;
                n_res.block_valid   = hit;
                n_res.chunk_sectors = read_chunk;
            end
            default: begin
                n_res = '0;
            end
        endcase
    end

    assign o_sts.clear_last = (r_page == pmbr_pkg::t_page'(pmbr_pkg::MAP_PAGES - 1));
    assign o_sts.write_last = (r_page == r_last);
    assign o_sts.commit_run = (r_req.req_type == pmbr_pkg::REQ_COMMIT) && count_nz;

    // sweep and commit share the one write port
    assign wr_en   = i_cmd.clear_step || i_cmd.write_step;
    assign wr_data = i_cmd.write_step ? {1'b1, r_req.commit_block} : '0;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_page] <= wr_data;
        end
        if (i_cmd.lookup) begin
            r_rdata <= r_mem[first_page];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page       <= '0;
            r_open_block <= '0;
            r_open_valid <= 1'b0;
            r_fill       <= '0;
            r_next       <= '0;
        end else begin
            if (i_cmd.clear_step || i_cmd.write_step) begin
                r_page <= r_page + pmbr_pkg::t_page'(1);
            end else if (i_cmd.lookup) begin
                r_page <= first_page;
            end
            if (i_cmd.eval && (r_req.req_type == pmbr_pkg::REQ_RESERVE) && grant) begin
                if (!r_open_valid) begin
                    r_open_block <= pmbr_pkg::t_blk'(r_next);
                    r_next       <= r_next + pmbr_pkg::t_next'(1);
                end
                if (new_fill >= pmbr_pkg::t_fill_sum'(pmbr_pkg::PAGE_PER_BLK)) begin
                    r_open_valid <= 1'b0;
                    r_fill       <= '0;
                end else begin
                    r_open_valid <= 1'b1;
                    r_fill       <= pmbr_pkg::t_fill'(new_fill);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_req;
        end
        if (i_cmd.lookup) begin
            r_last <= last_clip;
        end
        if (i_cmd.eval) begin
            r_res <= n_res;
        end
        if (i_cmd.load_out) begin
            r_rsp <= r_res;
        end
    end

    assign o_rsp = r_rsp;

endmodule

// File: hw/rtl/page_map_block_reserver_unit.sv
// top level of the page map block reserver
//
//  channel   valid     ready     payload
//  request   i_valid   o_ready   i_req  (pmbr_pkg::t_req)
//  result    o_valid   i_ready   o_rsp  (pmbr_pkg::t_rsp)
//
// reserve and read: the request passes the lookup state (registered read of the page
// table) and the evaluate state before the result is loaded; one request at a time
// commit: lookup, evaluate, then one page written per write step (map write port)
// after reset the page table is swept to invalid, all 4096 pages, with o_ready low
// a result waiting in the output register does not stop the next request;
// only loading a new result waits for the register to empty
module page_map_block_reserver_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  pmbr_pkg::t_req  i_req,
    output logic            o_valid,
    input  logic            i_ready,
    output pmbr_pkg::t_rsp  o_rsp
);

    pmbr_pkg::t_cmd cmd;
    pmbr_pkg::t_sts sts;

    pmbr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    pmbr_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_rsp   (o_rsp)
    );

endmodule

// File: hw/rtl/pmbr_checker.sv
// port-level checks of the page map block reserver and their binding
`include "assert_macros.svh"

module pmbr_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_valid,
    input logic            o_ready,
    input logic            o_valid,
    input logic            i_ready,
    input pmbr_pkg::t_rsp  o_rsp
);

    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid)
    `ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, o_valid && !i_ready, $stable(o_rsp))
    // one request in flight at a time
    `ASSERT_NEXT(a_busy_after_in, i_clk, i_rst_n, i_valid && o_ready, !o_ready)
    // map sweep keeps requests out right after reset
    `ASSERT_NEXT_ANY(a_sweep_after_rst, i_clk, !i_rst_n, !o_ready)

endmodule

bind page_map_block_reserver_unit pmbr_checker u_pmbr_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_rsp   (o_rsp)
);

// File: test/page_map_block_reserver_unit_tb.sv
// testbench for the page map block reserver: directed, stall, random and block exhaustion runs
`timescale 1ns / 1ps

module page_map_block_reserver_unit_tb;

    localparam logic [1:0] REQ_UNKNOWN    = 2'd3;
    localparam int         WATCHDOG_LIMIT = 20000;
    localparam int         RANDOM_ITEMS   = 80;
    localparam int         MAX_COUNT      = 8191;
    localparam int         MAX_START      = 32767;
    localparam int         MAX_BLK        = 1023;

    logic            i_clk   = 1'b0;
    logic            i_rst_n = 1'b0;
    logic            i_valid = 1'b0;
    logic            o_ready;
    pmbr_pkg::t_req  i_req   = '0;
    logic            o_valid;
    logic            i_ready = 1'b0;
    pmbr_pkg::t_rsp  o_rsp;

    // mirror of the block state
    pmbr_pkg::t_entry page_map [pmbr_pkg::MAP_PAGES];
    pmbr_pkg::t_blk   open_blk   = '0;
    logic             open_live  = 1'b0;
    int               open_fill  = 0;
    int               next_free  = 0;

    pmbr_pkg::t_rsp answer_q [$];
    int     fail_count = 0;
    int     idle_cycles = 0;
    bit     send_idle  = 1'b1;
    bit     rsp_idle   = 1'b1;
    int     rsp_hold   = 0;

    page_map_block_reserver_unit u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_rsp   (o_rsp)
    );

    always #5 i_clk = ~i_clk;

    // expected answer for one request, updating the mirrored map and reserver
    function automatic pmbr_pkg::t_rsp map_answer(input pmbr_pkg::t_req r);
        pmbr_pkg::t_rsp   a;
        pmbr_pkg::t_entry e;
        int     start, count, first_pg, last_pg, p;
        int     needed, room, to_edge, avail, grant, left;
        a        = '0;
        start    = int'(r.first_sector);
        count    = int'(r.sector_count);
        first_pg = start / pmbr_pkg::SEC_PER_PAGE;
        last_pg  = (start + count - 1) / pmbr_pkg::SEC_PER_PAGE;
        e        = (first_pg < pmbr_pkg::MAP_PAGES) ? page_map[first_pg] : '0;
        case (r.req_type)
            pmbr_pkg::REQ_RESERVE: begin
                if (e[pmbr_pkg::BLK_W]) begin
                    a.prior_valid = 1'b1;
                    a.prior_block = e[pmbr_pkg::BLK_W-1:0];
                end
                if (count != 0) begin
                    if (!open_live && next_free < pmbr_pkg::NUM_BLOCKS) begin
                        open_blk  = pmbr_pkg::t_blk'(next_free);
                        next_free = next_free + 1;
                        open_live = 1'b1;
                        open_fill = 0;
                    end
                    if (open_live) begin
                        needed  = last_pg - first_pg + 1;
                        room    = pmbr_pkg::PAGE_PER_BLK - open_fill;
                        to_edge = pmbr_pkg::PAGE_PER_BLK - first_pg % pmbr_pkg::PAGE_PER_BLK;
                        avail   = (room < to_edge) ? room : to_edge;
                        if (avail >= needed) begin
                            grant           = needed;
                            a.chunk_sectors = r.sector_count;
                        end else begin
                            grant           = avail;
                            a.chunk_sectors =
                                pmbr_pkg::t_count'(avail * pmbr_pkg::SEC_PER_PAGE);
                        end
                        a.block_addr  = open_blk;
                        a.block_valid = 1'b1;
                        open_fill     = open_fill + grant;
                        if (open_fill >= pmbr_pkg::PAGE_PER_BLK) begin
                            open_live = 1'b0;
                            open_fill = 0;
                        end
                    end
                end
            end
            pmbr_pkg::REQ_COMMIT: begin
                if (count != 0) begin
                    for (p = first_pg; p <= last_pg; p++) begin
                        if (p < pmbr_pkg::MAP_PAGES)
                            page_map[p] = {1'b1, r.commit_block};
                    end
                end
                a.block_addr    = r.commit_block;
                a.block_valid   = 1'b1;
                a.chunk_sectors = r.sector_count;
            end
            pmbr_pkg::REQ_READ: begin
                if (e[pmbr_pkg::BLK_W]) begin
                    left            = pmbr_pkg::SEC_PER_BLK - start % pmbr_pkg::SEC_PER_BLK;
                    a.block_addr    = e[pmbr_pkg::BLK_W-1:0];
                    a.block_valid   = 1'b1;
                    a.chunk_sectors = pmbr_pkg::t_count'((left < count) ? left : count);
                end else begin
                    a.chunk_sectors = r.sector_count;
                end
            end
            default: begin
            end
        endcase
        return a;
    endfunction

    function automatic pmbr_pkg::t_req make_req(input logic [1:0] kind, input int start,
                                                 input int count, input int blk);
        pmbr_pkg::t_req r;
        r.req_type     = kind;
        r.first_sector = pmbr_pkg::t_start'(start);
        r.sector_count = pmbr_pkg::t_count'(count);
        r.commit_block = pmbr_pkg::t_blk'(blk);
        return r;
    endfunction

    // mostly a low window so that reads and reserves meet committed pages
    function automatic int pick_start();
        if ($urandom_range(99) < 70)
            return $urandom_range(0, 2047);
        return $urandom_range(0, MAX_START);
    endfunction

    function automatic int pick_count();
        int sel;
        sel = $urandom_range(99);
        if (sel < 3)
            return 0;
        if (sel < 8)
            return $urandom_range(4096, MAX_COUNT);
        if (sel < 65)
            return $urandom_range(1, 24);
        return $urandom_range(25, 600);
    endfunction

    function automatic pmbr_pkg::t_req random_req();
        logic [1:0] kind;
        kind = 2'($urandom_range(0, 3));
        return make_req(kind, $urandom_range(0, MAX_START), pick_count(),
                        $urandom_range(0, MAX_BLK));
    endfunction

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_req(input pmbr_pkg::t_req r, output pmbr_pkg::t_rsp ans);
        while (send_idle && $urandom_range(99) < 37) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= r;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        ans = map_answer(r);
        answer_q.push_back(ans);
        @(negedge i_clk);
    endtask

    task automatic wait_for_results();
        i_valid <= 1'b0;
        while (answer_q.size() != 0)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s expected %0d got %0d", name, want, got);
            fail_count++;
        end
    endtask

    task automatic test_directed_cases();
        pmbr_pkg::t_rsp got;
        send_req(make_req(pmbr_pkg::REQ_READ, 0, 1, 0), got);
        send_req(make_req(pmbr_pkg::REQ_READ, MAX_START, MAX_COUNT, 0), got);
        send_req(make_req(pmbr_pkg::REQ_RESERVE, 0, 0, 0), got);
        send_req(make_req(pmbr_pkg::REQ_RESERVE, 0, 1, MAX_BLK), got);
        // last page before the logical block edge
        send_req(make_req(pmbr_pkg::REQ_RESERVE, 504, 100, 0), got);
        // clipped by the room left, fills and closes the block
        send_req(make_req(pmbr_pkg::REQ_RESERVE, 8, 4096, 0), got);
        send_req(make_req(pmbr_pkg::REQ_RESERVE, MAX_START, MAX_COUNT, 0), got);
        send_req(make_req(pmbr_pkg::REQ_COMMIT, 0, 8, MAX_BLK), got);
        // range runs past the end of the map
        send_req(make_req(pmbr_pkg::REQ_COMMIT, 32760, MAX_COUNT, 0), got);
        send_req(make_req(pmbr_pkg::REQ_COMMIT, 16, 0, 5), got);
        send_req(make_req(pmbr_pkg::REQ_READ, 16, 8, 0), got);
        send_req(make_req(pmbr_pkg::REQ_READ, 0, MAX_COUNT, 0), got);
        send_req(make_req(pmbr_pkg::REQ_READ, MAX_START, 1, 0), got);
        send_req(make_req(pmbr_pkg::REQ_READ, 0, 0, 0), got);
        send_req(make_req(pmbr_pkg::REQ_RESERVE, 0, 8, 0), got);
        send_req(make_req(pmbr_pkg::REQ_RESERVE, MAX_START, 0, 0), got);
        send_req(make_req(REQ_UNKNOWN, MAX_START, MAX_COUNT, MAX_BLK), got);
        send_req(make_req(REQ_UNKNOWN, 0, 0, 0), got);
        send_req(make_req(pmbr_pkg::REQ_COMMIT, 1000, 4096, 512), got);
        send_req(make_req(pmbr_pkg::REQ_READ, 1000, 30, 0), got);
        send_req(make_req(pmbr_pkg::REQ_READ, 5000, 4096, 0), got);
        wait_for_results();
    endtask

    task automatic test_output_stall();
        pmbr_pkg::t_rsp got;
        send_idle = 1'b0;
        rsp_hold  = 300;
        repeat (40) send_req(random_req(), got);
        send_idle = 1'b1;
        wait_for_results();
    endtask

    task automatic test_random_traffic();
        pmbr_pkg::t_rsp got, wr;
        int   n, start, count;
        n = 0;
        while (n < RANDOM_ITEMS) begin
            send_idle = !(n >= 20 && n < 50);
            rsp_idle  = send_idle;
            if ($urandom_range(99) < 55) begin
                // write flow: reserve, commit what was granted, read it back
                start = pick_start();
                count = pick_count();
                send_req(make_req(pmbr_pkg::REQ_RESERVE, start, count,
                                  $urandom_range(0, MAX_BLK)), wr);
                n++;
                if (wr.block_valid) begin
                    send_req(make_req(pmbr_pkg::REQ_COMMIT, start, int'(wr.chunk_sectors),
                                      int'(wr.block_addr)), got);
                    send_req(make_req(pmbr_pkg::REQ_READ, start, pick_count(), 0), got);
                    n += 2;
                end
            end else begin
                send_req(random_req(), got);
                n++;
            end
        end
        send_idle = 1'b1;
        rsp_idle  = 1'b1;
        wait_for_results();
    endtask

    task automatic test_block_exhaustion();
        pmbr_pkg::t_rsp got;
        while (next_free < pmbr_pkg::NUM_BLOCKS || open_live) begin
            if ($urandom_range(31) == 0)
                send_req(make_req(pmbr_pkg::REQ_READ, pick_start(), pick_count(), 0), got);
            else
                send_req(make_req(pmbr_pkg::REQ_RESERVE,
                                  $urandom_range(0, 63) * pmbr_pkg::SEC_PER_BLK,
                                  $urandom_range(pmbr_pkg::SEC_PER_BLK, MAX_COUNT),
                                  $urandom_range(0, MAX_BLK)), got);
        end
        // nothing left to open
        send_req(make_req(pmbr_pkg::REQ_RESERVE, 0, 8, 0), got);
        send_req(make_req(pmbr_pkg::REQ_RESERVE, 0, 0, 0), got);
        repeat (20) send_req(random_req(), got);
        wait_for_results();
    endtask

    initial begin : result_sink
        forever begin
            @(negedge i_clk);
            if (rsp_hold > 0) begin
                i_ready  <= 1'b0;
                rsp_hold = rsp_hold - 1;
            end else if (rsp_idle) begin
                i_ready <= ($urandom_range(99) >= 37);
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        pmbr_pkg::t_rsp want;
        if (i_rst_n && o_valid && i_ready) begin
            if (answer_q.size() == 0) begin
                $error("result transfer with no answer expected");
                fail_count++;
            end else begin
                want = answer_q.pop_front();
                check_field("block_addr", int'(want.block_addr), int'(o_rsp.block_addr));
                check_field("block_valid", int'(want.block_valid), int'(o_rsp.block_valid));
                check_field("prior_block", int'(want.prior_block), int'(o_rsp.prior_block));
                check_field("prior_valid", int'(want.prior_valid), int'(o_rsp.prior_valid));
                check_field("chunk_sectors", int'(want.chunk_sectors),
                            int'(o_rsp.chunk_sectors));
            end
        end
    end

    // long table sweep after reset and long commits stay well inside the limit
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("page_map_block_reserver_unit verification failed");
            $finish;
        end
    end

    initial begin
        foreach (page_map[i])
            page_map[i] = '0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_cases();
        test_output_stall();
        test_random_traffic();
        test_block_exhaustion();
        wait_for_results();
        repeat (32) @(posedge i_clk);
        if (fail_count == 0 && answer_q.size() == 0)
            $display("page_map_block_reserver_unit verification clean");
        else
            $display("page_map_block_reserver_unit verification failed");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/pmbr_pkg.sv
hw/rtl/pmbr_ctrl.sv
hw/rtl/pmbr_dp.sv
hw/rtl/page_map_block_reserver_unit.sv
hw/rtl/pmbr_checker.sv
test/page_map_block_reserver_unit_tb.sv
